// ----- rtl/uvob_pkg.sv -----
// ----------------------------------------------------------------------------
// uvob_pkg
// Shared types, constants and helpers for the orthonormal basis block.
// ----------------------------------------------------------------------------
package uvob_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;   // data width of every matrix entry
  localparam int TOL_W     = 21;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(65536);

  // squared norm of one in units of 2^-2F
  localparam logic [31:0] NORM_ONE = 32'(1) << (2 * FRAC_BITS);

  // digit-by-digit root: one result bit per step over a 30-bit radicand
  localparam int SQ_STEPS  = 15;
  // restoring divide: one quotient bit per step
  localparam int DIV_STEPS = 17;

  localparam logic [1:0] AXIS_BAD = 2'd3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NORM = 2'd1,
    ST_AXIS = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DW-1:0] ux;
    logic signed [DW-1:0] uy;
    logic signed [DW-1:0] uz;
    logic [1:0]           axis;
    logic [1:0]           idx;
    status_e              status;
  } meta_t;

  // magnitude of a 16-bit signed value, -32768 gives 32768
  function automatic logic [DW:0] mag16(logic signed [DW-1:0] x);
    logic signed [DW:0] e;
    e = {x[DW-1], x};
    return x[DW-1] ? (DW+1)'(0) - e : e;
  endfunction

  // next index modulo 3
  function automatic logic [1:0] next3(logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  function automatic logic signed [DW-1:0] sat16(logic signed [DIV_STEPS:0] x);
    logic signed [DIV_STEPS:0] hi;
    logic signed [DIV_STEPS:0] lo;
    hi = (DIV_STEPS+1)'(32767);
    lo = -(DIV_STEPS+1)'(32768);
    if (x > hi) return 16'sh7fff;
    else if (x < lo) return 16'sh8000;
    else return x[DW-1:0];
  endfunction

endpackage

// ----- rtl/uvob_cfg_if.sv -----
// ----------------------------------------------------------------------------
// uvob_cfg_if
// Register write channel: tolerance of the squared norm check.
// ----------------------------------------------------------------------------
interface uvob_cfg_if;
  logic        valid;
  logic        ready;
  logic [20:0] norm_tolerance;

  modport source (output valid, output norm_tolerance, input ready);
  modport sink   (input valid, input norm_tolerance, output ready);
endinterface

// ----- rtl/uvob_in_if.sv -----
// ----------------------------------------------------------------------------
// uvob_in_if
// Input stream: unit vector in Q2.14 and target column.
// ----------------------------------------------------------------------------
interface uvob_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] u_x;
  logic signed [15:0] u_y;
  logic signed [15:0] u_z;
  logic [1:0]         col_sel;

  modport source (output valid, output u_x, output u_y, output u_z, output col_sel,
                  input ready);
  modport sink   (input valid, input u_x, input u_y, input u_z, input col_sel,
                  output ready);
endinterface

// ----- rtl/uvob_out_if.sv -----
// ----------------------------------------------------------------------------
// uvob_out_if
// Output stream: 3x3 rotation matrix in Q2.14 and status.
// ----------------------------------------------------------------------------
interface uvob_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00, m01, m02;
  logic signed [15:0] m10, m11, m12;
  logic signed [15:0] m20, m21, m22;
  logic [1:0]         status;

  modport source (output valid, output m00, output m01, output m02, output m10, output m11,
                  output m12, output m20, output m21, output m22, output status,
                  input ready);
  modport sink   (input valid, input m00, input m01, input m02, input m10, input m11,
                  input m12, input m20, input m21, input m22, input status,
                  output ready);
endinterface

// ----- rtl/unit_vector_to_orthonormal_basis.sv -----
// ----------------------------------------------------------------------------
// unit_vector_to_orthonormal_basis
// Right-handed orthonormal basis whose column at col_sel is the input.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat in and one beat out per cycle while out_o.ready
// is high. The pipeline holds the square root (15 stages, one result bit
// each) and the four parallel dividers (17 stages, one quotient bit each)
// behind a square/select stage, a norm check stage and a rounding stage;
// the last stage is the output register. Each stage holds its own
// valid bit and advances when the stage ahead is empty or moving, so bubbles
// fill up under back-pressure. A status of 1 (norm off by more than
// norm_tolerance) or 2 (col_sel 3) comes with an all-zero matrix.
module unit_vector_to_orthonormal_basis (
  input  logic     clk_i,
  input  logic     rst_ni,
  uvob_cfg_if.sink cfg_i,
  uvob_in_if.sink  in_i,
  uvob_out_if.source out_o
);
  import uvob_pkg::*;

  localparam int ST_S0       = 0;
  localparam int ST_S1       = 1;
  localparam int ST_SQ0      = 2;
  localparam int ST_SQ_LAST  = ST_SQ0 + SQ_STEPS - 1;
  localparam int ST_RND      = ST_SQ_LAST + 1;
  localparam int ST_DIV0     = ST_RND + 1;
  localparam int ST_DIV_LAST = ST_DIV0 + DIV_STEPS - 1;
  localparam int NST         = ST_DIV_LAST + 2;
  localparam int NW          = 2 * FRAC_BITS + 3;   // numerator magnitude width

  // ---------------- configuration ----------------
  logic [TOL_W-1:0] tol_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.norm_tolerance;
    end
  end

  // ---------------- flow control ----------------
  logic [NST-1:0] vld_q;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = !vld_q[NST-1] || out_o.ready;
    for (int s = NST - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~adv) | ({vld_q[NST-2:0], in_i.valid} & adv);
    end
  end

  assign in_i.ready  = adv[0];
  assign out_o.valid = vld_q[NST-1];

  // ---------------- pipeline storage ----------------
  meta_t             meta_q [ST_S0:ST_DIV_LAST];
  logic [2*DW-2:0]   sq_q   [3];
  logic [NW-1:0]     nmag_q [ST_S1:ST_SQ_LAST][4];
  logic [3:0]        neg_q  [ST_S1:ST_DIV_LAST];
  logic [29:0]       sn_q   [ST_S1:ST_SQ_LAST];
  logic [29:0]       sr_q   [ST_S1:ST_SQ_LAST];
  logic [DW-2:0]     m_q    [ST_RND:ST_DIV_LAST];
  logic [NW:0]       rem_q  [ST_RND:ST_DIV_LAST][4];
  logic [DIV_STEPS-1:0] quo_q [ST_DIV0:ST_DIV_LAST][4];

  // ---------------- stage 0: squares, smallest component ----------------
  logic [DW:0]     mg0 [3];
  logic [1:0]      idx0;
  meta_t           meta0;

  always_comb begin
    mg0[0] = mag16(in_i.u_x);
    mg0[1] = mag16(in_i.u_y);
    mg0[2] = mag16(in_i.u_z);
    idx0   = 2'd0;
    if (mg0[1] < mg0[0]) idx0 = 2'd1;
    if (mg0[2] < mg0[idx0]) idx0 = 2'd2;
    meta0.ux     = in_i.u_x;
    meta0.uy     = in_i.u_y;
    meta0.uz     = in_i.u_z;
    meta0.axis   = in_i.col_sel;
    meta0.idx    = idx0;
    meta0.status = ST_OK;
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_S0]) begin
      meta_q[ST_S0] <= meta0;
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= (2*DW-1)'(mg0[c] * mg0[c]);
      end
    end
  end

  // ---------------- stage 1: norm check, radicand, numerators ----------------
  logic [31:0]           nsq1, dev1;
  logic signed [32:0]    dd1;
  logic signed [DW-1:0]  u1 [3];
  logic signed [DW-1:0]  ui1, uj1, uk1;
  logic signed [2*DW-1:0] pij1, pik1;
  logic [1:0]            j1, k1;
  meta_t                 meta1;
  logic [29:0]           rad1;
  logic [NW-1:0]         nm1 [4];
  logic [3:0]            ng1;

  always_comb begin
    meta1 = meta_q[ST_S0];
    u1[0] = meta1.ux;
    u1[1] = meta1.uy;
    u1[2] = meta1.uz;
    j1    = next3(meta1.idx);
    k1    = next3(j1);
    ui1   = u1[meta1.idx];
    uj1   = u1[j1];
    uk1   = u1[k1];

    nsq1 = 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
    dev1 = (nsq1 >= NORM_ONE) ? nsq1 - NORM_ONE : NORM_ONE - nsq1;
    if (meta1.axis == AXIS_BAD) meta1.status = ST_AXIS;
    else if (dev1 > 32'(tol_q)) meta1.status = ST_NORM;
    else meta1.status = ST_OK;

    // radicand clamps at one least unit
    dd1  = $signed({1'b0, NORM_ONE}) - $signed(33'(sq_q[meta1.idx]));
    rad1 = (dd1 < 33'sd1) ? 30'd1 : dd1[29:0];

    pij1 = ui1 * uj1;
    pik1 = ui1 * uk1;

    // v_j = -u_k/m, v_k = u_j/m, w_j = -u_i*u_j/m, w_k = -u_i*u_k/m
    nm1[0] = NW'(mag16(uk1)) << FRAC_BITS;
    ng1[0] = !uk1[DW-1];
    nm1[1] = NW'(mag16(uj1)) << FRAC_BITS;
    ng1[1] = uj1[DW-1];
    nm1[2] = pij1[2*DW-1] ? NW'(-pij1) : NW'(pij1);
    ng1[2] = !pij1[2*DW-1];
    nm1[3] = pik1[2*DW-1] ? NW'(-pik1) : NW'(pik1);
    ng1[3] = !pik1[2*DW-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_S1]) begin
      meta_q[ST_S1] <= meta1;
      sn_q[ST_S1]   <= rad1;
      sr_q[ST_S1]   <= '0;
      nmag_q[ST_S1] <= nm1;
      neg_q[ST_S1]  <= ng1;
    end
  end

  // ---------------- square root, one result bit a stage ----------------
  for (genvar t = 0; t < SQ_STEPS; t++) begin : g_sqrt
    localparam int S = ST_SQ0 + t;
    localparam logic [29:0] BIT = 30'(1) << (2 * (SQ_STEPS - 1 - t));
    logic [29:0] trial;
    logic [29:0] sn_d, sr_d;

    always_comb begin
      trial = sr_q[S-1] + BIT;
      if (sn_q[S-1] >= trial) begin
        sn_d = sn_q[S-1] - trial;
        sr_d = (sr_q[S-1] >> 1) + BIT;
      end else begin
        sn_d = sn_q[S-1];
        sr_d = sr_q[S-1] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[S]) begin
        meta_q[S] <= meta_q[S-1];
        sn_q[S]   <= sn_d;
        sr_q[S]   <= sr_d;
        nmag_q[S] <= nmag_q[S-1];
        neg_q[S]  <= neg_q[S-1];
      end
    end
  end

  // ---------------- rounding of m, dividend bias ----------------
  logic [DW-2:0] m_rnd;

  always_comb begin
    m_rnd = sr_q[ST_SQ_LAST][DW-2:0] +
            (DW-1)'(sn_q[ST_SQ_LAST] > sr_q[ST_SQ_LAST]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_RND]) begin
      meta_q[ST_RND] <= meta_q[ST_SQ_LAST];
      neg_q[ST_RND]  <= neg_q[ST_SQ_LAST];
      m_q[ST_RND]    <= m_rnd;
      for (int l = 0; l < 4; l++) begin
        rem_q[ST_RND][l] <= (NW+1)'(nmag_q[ST_SQ_LAST][l]) + (NW+1)'(m_rnd >> 1);
      end
    end
  end

  // ---------------- four restoring dividers, one quotient bit a stage ----------------
  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
    localparam int S = ST_DIV0 + t;
    localparam int B = DIV_STEPS - 1 - t;
    logic [NW:0]          sub;
    logic [NW:0]          rem_d [4];
    logic [DIV_STEPS-1:0] quo_d [4];

    always_comb begin
      sub = (NW+1)'(m_q[S-1]) << B;
      for (int l = 0; l < 4; l++) begin
        logic [DIV_STEPS-1:0] prev;
        logic                 hit;
        prev = (t == 0) ? '0 : quo_q[(t == 0) ? ST_DIV0 : S-1][l];
        hit  = rem_q[S-1][l] >= sub;
        rem_d[l] = hit ? rem_q[S-1][l] - sub : rem_q[S-1][l];
        quo_d[l] = {prev[DIV_STEPS-2:0], hit};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[S]) begin
        meta_q[S] <= meta_q[S-1];
        neg_q[S]  <= neg_q[S-1];
        m_q[S]    <= m_q[S-1];
        rem_q[S]  <= rem_d;
        quo_q[S]  <= quo_d;
      end
    end
  end

  // ---------------- output stage: signs, placement, saturation ----------------
  logic signed [DW-1:0] mat_q [9];
  status_e              status_q;
  logic signed [DW-1:0] mat_d [9];
  logic signed [DW-1:0] val_f [4];
  logic signed [DW-1:0] uf [3], vf [3], wf [3];
  logic [1:0]           jf, kf, c1f, c2f;
  meta_t                metaf;

  always_comb begin
    metaf = meta_q[ST_DIV_LAST];
    for (int l = 0; l < 4; l++) begin
      logic signed [DIV_STEPS:0] q;
      q = $signed({1'b0, quo_q[ST_DIV_LAST][l]});
      val_f[l] = sat16(neg_q[ST_DIV_LAST][l] ? -q : q);
    end
    uf[0] = metaf.ux;
    uf[1] = metaf.uy;
    uf[2] = metaf.uz;
    jf  = next3(metaf.idx);
    kf  = next3(jf);
    c1f = next3(metaf.axis);
    c2f = next3(c1f);
    for (int r = 0; r < 3; r++) begin
      if (2'(r) == metaf.idx) begin
        vf[r] = '0;
        wf[r] = DW'(m_q[ST_DIV_LAST]);
      end else if (2'(r) == jf) begin
        vf[r] = val_f[0];
        wf[r] = val_f[2];
      end else begin
        vf[r] = val_f[1];
        wf[r] = val_f[3];
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (metaf.status != ST_OK) mat_d[r*3+c] = '0;
        else if (2'(c) == metaf.axis) mat_d[r*3+c] = uf[r];
        else if (2'(c) == c1f) mat_d[r*3+c] = vf[r];
        else if (2'(c) == c2f) mat_d[r*3+c] = wf[r];
        else mat_d[r*3+c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NST-1]) begin
      mat_q    <= mat_d;
      status_q <= metaf.status;
    end
  end

  assign out_o.m00    = mat_q[0];
  assign out_o.m01    = mat_q[1];
  assign out_o.m02    = mat_q[2];
  assign out_o.m10    = mat_q[3];
  assign out_o.m11    = mat_q[4];
  assign out_o.m12    = mat_q[5];
  assign out_o.m20    = mat_q[6];
  assign out_o.m21    = mat_q[7];
  assign out_o.m22    = mat_q[8];
  assign out_o.status = status_q;

  // ---------------- assertions ----------------
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_OK |->
      out_o.m00 == 0 && out_o.m01 == 0 && out_o.m02 == 0 &&
      out_o.m10 == 0 && out_o.m11 == 0 && out_o.m12 == 0 &&
      out_o.m20 == 0 && out_o.m21 == 0 && out_o.m22 == 0)
    else $error("error status with nonzero matrix");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q) && !out_o.ready)
    else $error("input stalled while pipeline has a bubble");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_RND] && meta_q[ST_RND].status == ST_OK |-> m_q[ST_RND] != 0)
    else $error("zero divisor on a valid item");

endmodule
